// ----- rtl/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants for the keyframe curve evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned T_W         = 31;           // Q1.30 segment parameter
  localparam int unsigned FRAC_W      = 30;
  localparam int unsigned WIDE_W      = VAL_W + 4;    // evaluation headroom
  localparam int unsigned NUM_W       = WIDE_W + 1;
  localparam int unsigned DK_W        = VAL_W + 1;
  localparam int unsigned PROD_W      = 2 * DK_W;

  localparam logic [T_W-1:0] ONE_Q30 = T_W'(1) << FRAC_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_BEZIER = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PATH_EMPTY  = 3'd0,
    PATH_CLAMP  = 3'd1,
    PATH_CONST  = 3'd2,
    PATH_LINEAR = 3'd3,
    PATH_BEZIER = 3'd4
  } path_e;

  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT = 2'd0,
    CFG_TOLERANCE   = 2'd1,
    CFG_MAX_ITER    = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [VAL_W-1:0]  rval;
    logic [VAL_W-1:0]  rkey;
    logic [VAL_W-1:0]  lval;
    logic [VAL_W-1:0]  lkey;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  key;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHKL,
    ST_SCAN,
    ST_LIN_T,
    ST_LIN_TW,
    ST_LIN_MUL,
    ST_LIN_ADD,
    ST_BZ_T,
    ST_BZ_TW,
    ST_BZ_C,
    ST_BZ_CW,
    ST_BZ_CHK,
    ST_BV_T,
    ST_BV_TW,
    ST_BV_C,
    ST_BV_CW,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/kce_entry_ram.sv -----
// ----------------------------------------------------------------------------
// kce_entry_ram
// Simple dual port synchronous RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kce_entry_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kce_divider.sv -----
// ----------------------------------------------------------------------------
// kce_divider
// Segment parameter t = floor(num * 2^30 / den), clamped to [0, 1].
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kce_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [kce_pkg::NUM_W-1:0] num_i,
  input  logic signed [kce_pkg::DK_W-1:0]  den_i,
  output logic                            done_o,
  output logic [kce_pkg::T_W-1:0]          quo_o
);

  localparam int unsigned REM_W = kce_pkg::DK_W + 1;

  logic                           busy_q;
  logic                           done_q;
  logic [4:0]                     cnt_q;
  logic [REM_W-1:0]               rem_q;
  logic [kce_pkg::FRAC_W-1:0]     q_q;
  logic [kce_pkg::T_W-1:0]        quo_q;
  logic [REM_W-1:0]               rem2;
  logic [REM_W-1:0]               den_ext;
  logic                           qbit;
  logic signed [kce_pkg::NUM_W-1:0] den_cmp;

  assign rem2    = {rem_q[REM_W-2:0], 1'b0};
  assign den_ext = REM_W'(unsigned'(den_i));
  assign qbit    = (rem2 >= den_ext);
  assign den_cmp = kce_pkg::NUM_W'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i <= 0 || num_i >= den_cmp) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(kce_pkg::FRAC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(unsigned'(num_i[kce_pkg::VAL_W-1:0]));
      q_q   <= '0;
      if (num_i <= 0) begin
        quo_q <= '0;
      end else if (num_i >= den_cmp) begin
        quo_q <= kce_pkg::ONE_Q30;
      end
    end else if (busy_q) begin
      rem_q <= qbit ? (rem2 - den_ext) : rem2;
      q_q   <= {q_q[kce_pkg::FRAC_W-2:0], qbit};
      if (cnt_q == 5'(kce_pkg::FRAC_W - 1)) begin
        quo_q <= {1'b0, q_q[kce_pkg::FRAC_W-2:0], qbit};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/kce_cubic.sv -----
// ----------------------------------------------------------------------------
// kce_cubic
// Cubic Bezier point at parameter t, Q1.30 basis, round half up.
// One shared registered multiplier stepped through the basis and the sum.
// ----------------------------------------------------------------------------
module kce_cubic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [kce_pkg::T_W-1:0]           t_i,
  input  logic [kce_pkg::VAL_W-1:0]         p0_i,
  input  logic [kce_pkg::VAL_W-1:0]         p1_i,
  input  logic [kce_pkg::VAL_W-1:0]         p2_i,
  input  logic [kce_pkg::VAL_W-1:0]         p3_i,
  output logic                             done_o,
  output logic signed [kce_pkg::WIDE_W-1:0] value_o
);

  localparam int unsigned OP_W = kce_pkg::DK_W;
  localparam int unsigned P_W  = kce_pkg::PROD_W;
  localparam int unsigned T_W  = kce_pkg::T_W;
  localparam int unsigned V_W  = kce_pkg::VAL_W;
  localparam int unsigned F_W  = kce_pkg::FRAC_W;
  localparam logic [3:0] LAST_STEP = 4'd11;

  logic                    busy_q;
  logic                    done_q;
  logic [3:0]              step_q;
  logic [T_W-1:0]          t_q, u_q, t2_q, u2_q, t3_q, u3_q;
  logic [V_W-1:0]          w1_q, w2_q;
  logic [V_W-1:0]          p0_q, p1_q, p2_q, p3_q;
  logic signed [P_W-1:0]   prod_q;
  logic signed [P_W-1:0]   acc_q;
  logic signed [P_W-1:0]   rnd;
  logic signed [kce_pkg::WIDE_W-1:0] res_q;
  logic signed [OP_W-1:0]  op_a, op_b;
  logic [T_W-1:0]          frac;
  logic [V_W-1:0]          triple;

  assign frac   = prod_q[F_W+T_W-1:F_W];
  assign triple = {1'b0, frac} + {frac, 1'b0};
  assign rnd    = acc_q + (P_W'(1) <<< (F_W - 1));

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      4'd0: begin op_a = OP_W'(t_q);  op_b = OP_W'(t_q); end
      4'd1: begin op_a = OP_W'(u_q);  op_b = OP_W'(u_q); end
      4'd2: begin op_a = OP_W'(t2_q); op_b = OP_W'(t_q); end
      4'd3: begin op_a = OP_W'(u2_q); op_b = OP_W'(u_q); end
      4'd4: begin op_a = OP_W'(u2_q); op_b = OP_W'(t_q); end
      4'd5: begin op_a = OP_W'(u_q);  op_b = OP_W'(t2_q); end
      4'd6: begin op_a = OP_W'(u3_q); op_b = {p0_q[V_W-1], p0_q}; end
      4'd7: begin op_a = OP_W'(w1_q); op_b = {p1_q[V_W-1], p1_q}; end
      4'd8: begin op_a = OP_W'(w2_q); op_b = {p2_q[V_W-1], p2_q}; end
      4'd9: begin op_a = OP_W'(t3_q); op_b = {p3_q[V_W-1], p3_q}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (start_i) begin
      t_q  <= t_i;
      u_q  <= kce_pkg::ONE_Q30 - t_i;
      p0_q <= p0_i;
      p1_q <= p1_i;
      p2_q <= p2_i;
      p3_q <= p3_i;
    end else if (busy_q) begin
      unique case (step_q)
        4'd1:  t2_q  <= frac;
        4'd2:  u2_q  <= frac;
        4'd3:  t3_q  <= frac;
        4'd4:  u3_q  <= frac;
        4'd5:  w1_q  <= triple;
        4'd6:  w2_q  <= triple;
        4'd7:  acc_q <= prod_q;
        4'd8, 4'd9, 4'd10: acc_q <= acc_q + prod_q;
        4'd11: res_q <= rnd[P_W-1:F_W];
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = res_q;

endmodule

// ----- rtl/keyframe_curve_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_top
// Keyframe table in RAM; evaluates constant, linear and cubic Bezier curves.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one keyframe. An evaluate beat (tuser 1)
// offers its result beat straight from idle for an empty table; otherwise
// it checks the first key (clamp at the first key), then the last key (clamp
// at the last key), then scans the keyframe keys in the RAM one key per cycle
// until a segment is found (constant and zero length segments stop there). A
// linear segment then runs the restoring divider, a multiply and an add; a
// Bezier segment runs, per search pass, the restoring divider and the 12-step
// shared multiplier cubic, then both once more for the final value cubic. The
// divider skips its restoring steps when the segment parameter clamps to 0 or
// 1. The one RAM read port, the divider and the shared multiplier pace each
// evaluation. One item at a time. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] entry_index, [37:6] key_position, [69:38] entry_value,
  // [101:70] left_handle_key, [133:102] left_handle_value,
  // [165:134] right_handle_key, [197:166] right_handle_value,
  // [199:198] entry_mode
  input  logic [199:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]   s_axis_tuser,
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] curve_value
  output logic [31:0]  m_axis_tdata,
  // [2:0] path_taken, [3] search_converged
  output logic [3:0]   m_axis_tuser,
  // configuration
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned A_W  = kce_pkg::ADDR_W;
  localparam int unsigned C_W  = kce_pkg::CNT_W;
  localparam int unsigned V_W  = kce_pkg::VAL_W;
  localparam int unsigned W_W  = kce_pkg::WIDE_W;
  localparam int unsigned N_W  = kce_pkg::NUM_W;
  localparam int unsigned D_W  = kce_pkg::DK_W;
  localparam int unsigned P_W  = kce_pkg::PROD_W;
  localparam int unsigned T_W  = kce_pkg::T_W;
  localparam int unsigned F_W  = kce_pkg::FRAC_W;
  localparam int unsigned E_W  = $bits(kce_pkg::entry_t);

  kce_pkg::state_e state_q, state_d;

  logic [C_W-1:0]  entry_count_q;
  logic [15:0]     tol_q;
  logic [7:0]      max_iter_q;

  logic signed [V_W-1:0] key_q;
  logic signed [W_W-1:0] cur_q;
  kce_pkg::entry_t       seg0_q, seg1_q;
  logic [A_W-1:0]        s_q;
  logic [T_W-1:0]        t_q;
  logic signed [P_W-1:0] lin_prod_q;
  logic [7:0]            passes_q;
  logic signed [W_W-1:0] res_q;
  kce_pkg::path_e        path_q;
  logic                  conv_q;

  kce_pkg::entry_t       wr_entry, rd_entry;
  logic [E_W-1:0]        rd_raw;
  logic                  ram_we;
  logic [A_W-1:0]        rd_addr;
  logic                  in_fire, out_fire, is_eval;

  logic [C_W-1:0]        count;
  logic [A_W-1:0]        last;
  logic                  scan_more;
  logic signed [D_W-1:0] scan_dk, seg_dk;
  logic                  seg_bez, seg_lin;

  logic                  div_start, div_done;
  logic [T_W-1:0]        div_quo;
  logic signed [N_W-1:0] div_num;
  logic                  cub_start, cub_done;
  logic signed [W_W-1:0] cub_val;
  logic [V_W-1:0]        cp0, cp1, cp2, cp3;

  logic signed [N_W-1:0] diff;
  logic signed [N_W-1:0] tol_s;
  logic                  within_tol, between, pass_more;
  logic signed [N_W-1:0] mid_sum;
  logic signed [D_W-1:0] lin_dv;
  logic signed [P_W-1:0] lin_rnd;
  logic signed [W_W-1:0] lin_res;
  logic signed [W_W-1:0] sat_hi, sat_lo;

  // ---- handshakes and configuration ----
  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign out_fire    = m_axis_tvalid & m_axis_tready;
  assign is_eval     = (kce_pkg::opcode_e'(s_axis_tuser[0]) == kce_pkg::OP_EVAL);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      tol_q         <= 16'd66;
      max_iter_q    <= 8'd16;
    end else if (cfg_valid_i) begin
      unique case (kce_pkg::cfg_idx_e'(cfg_index_i))
        kce_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[C_W-1:0];
        kce_pkg::CFG_TOLERANCE:   tol_q         <= cfg_data_i;
        kce_pkg::CFG_MAX_ITER:    max_iter_q    <= cfg_data_i[7:0];
        kce_pkg::CFG_NONE:        ;
      endcase
    end
  end

  assign count = (entry_count_q > C_W'(kce_pkg::MAX_ENTRIES)) ?
                 C_W'(kce_pkg::MAX_ENTRIES) : entry_count_q;
  assign last  = A_W'(count - C_W'(1));

  // ---- keyframe RAM ----
  assign wr_entry.key   = s_axis_tdata[37:6];
  assign wr_entry.value = s_axis_tdata[69:38];
  assign wr_entry.lkey  = s_axis_tdata[101:70];
  assign wr_entry.lval  = s_axis_tdata[133:102];
  assign wr_entry.rkey  = s_axis_tdata[165:134];
  assign wr_entry.rval  = s_axis_tdata[197:166];
  assign wr_entry.mode  = s_axis_tdata[199:198];
  assign ram_we         = in_fire & ~is_eval;

  kce_entry_ram #(
    .WIDTH (E_W),
    .DEPTH (kce_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_axis_tdata[A_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  assign rd_entry = kce_pkg::entry_t'(rd_raw);

  // ---- segment search ----
  assign scan_more = (s_q < last) && (key_q >= $signed(rd_entry.key));
  assign scan_dk   = D_W'($signed(rd_entry.key)) - D_W'($signed(seg0_q.key));
  assign seg_dk    = D_W'($signed(seg1_q.key)) - D_W'($signed(seg0_q.key));
  assign seg_bez   = (kce_pkg::mode_e'(seg0_q.mode) == kce_pkg::MODE_BEZIER) &&
                     (kce_pkg::mode_e'(rd_entry.mode) == kce_pkg::MODE_BEZIER);
  assign seg_lin   = (kce_pkg::mode_e'(seg0_q.mode) == kce_pkg::MODE_BEZIER) ||
                     (kce_pkg::mode_e'(seg0_q.mode) == kce_pkg::MODE_LINEAR);

  // ---- arithmetic units ----
  assign div_num = N_W'(cur_q) - N_W'($signed(seg0_q.key));

  kce_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (seg_dk),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    if (state_q == kce_pkg::ST_BV_C) begin
      cp0 = seg0_q.value;
      cp1 = seg0_q.rval;
      cp2 = seg1_q.lval;
      cp3 = seg1_q.value;
    end else begin
      cp0 = seg0_q.key;
      cp1 = seg0_q.rkey;
      cp2 = seg1_q.lkey;
      cp3 = seg1_q.key;
    end
  end

  kce_cubic u_cubic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cub_start),
    .t_i     (t_q),
    .p0_i    (cp0),
    .p1_i    (cp1),
    .p2_i    (cp2),
    .p3_i    (cp3),
    .done_o  (cub_done),
    .value_o (cub_val)
  );

  // bezier search step
  assign diff       = N_W'(cub_val) - N_W'(key_q);
  assign tol_s      = N_W'(tol_q);
  assign within_tol = (diff <= tol_s) && (diff >= -tol_s);
  assign between    = ((cub_val < cur_q) && (cub_val > W_W'(key_q))) ||
                      ((cub_val > cur_q) && (cub_val < W_W'(key_q)));
  assign mid_sum    = N_W'(cub_val) + N_W'(key_q);
  assign pass_more  = ({1'b0, passes_q} + 9'd1) < {1'b0, max_iter_q};

  // linear
  assign lin_dv  = D_W'($signed(seg1_q.value)) - D_W'($signed(seg0_q.value));
  assign lin_rnd = lin_prod_q + (P_W'(1) <<< (F_W - 1));
  assign lin_res = W_W'($signed(seg0_q.value)) + lin_rnd[P_W-1:F_W];

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kce_pkg::ST_IDLE: begin
        if (in_fire && is_eval) begin
          state_d = (count == '0) ? kce_pkg::ST_OUT : kce_pkg::ST_CHK0;
        end
      end
      kce_pkg::ST_CHK0: begin
        if (count == C_W'(1) || key_q <= $signed(rd_entry.key)) begin
          state_d = kce_pkg::ST_OUT;
        end else begin
          state_d = kce_pkg::ST_CHKL;
        end
      end
      kce_pkg::ST_CHKL: begin
        state_d = (key_q >= $signed(rd_entry.key)) ? kce_pkg::ST_OUT : kce_pkg::ST_SCAN;
      end
      kce_pkg::ST_SCAN: begin
        if (scan_more) begin
          state_d = kce_pkg::ST_SCAN;
        end else if (seg_bez) begin
          state_d = (scan_dk <= 0) ? kce_pkg::ST_OUT : kce_pkg::ST_BZ_T;
        end else if (seg_lin) begin
          state_d = (scan_dk <= 0) ? kce_pkg::ST_OUT : kce_pkg::ST_LIN_T;
        end else begin
          state_d = kce_pkg::ST_OUT;
        end
      end
      kce_pkg::ST_LIN_T:   state_d = kce_pkg::ST_LIN_TW;
      kce_pkg::ST_LIN_TW:  if (div_done) state_d = kce_pkg::ST_LIN_MUL;
      kce_pkg::ST_LIN_MUL: state_d = kce_pkg::ST_LIN_ADD;
      kce_pkg::ST_LIN_ADD: state_d = kce_pkg::ST_OUT;
      kce_pkg::ST_BZ_T:    state_d = kce_pkg::ST_BZ_TW;
      kce_pkg::ST_BZ_TW:   if (div_done) state_d = kce_pkg::ST_BZ_C;
      kce_pkg::ST_BZ_C:    state_d = kce_pkg::ST_BZ_CW;
      kce_pkg::ST_BZ_CW:   if (cub_done) state_d = kce_pkg::ST_BZ_CHK;
      kce_pkg::ST_BZ_CHK: begin
        state_d = (!within_tol && pass_more) ? kce_pkg::ST_BZ_T : kce_pkg::ST_BV_T;
      end
      kce_pkg::ST_BV_T:    state_d = kce_pkg::ST_BV_TW;
      kce_pkg::ST_BV_TW:   if (div_done) state_d = kce_pkg::ST_BV_C;
      kce_pkg::ST_BV_C:    state_d = kce_pkg::ST_BV_CW;
      kce_pkg::ST_BV_CW:   if (cub_done) state_d = kce_pkg::ST_OUT;
      kce_pkg::ST_OUT:     if (out_fire) state_d = kce_pkg::ST_IDLE;
      default:             state_d = kce_pkg::ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    cub_start     = 1'b0;
    rd_addr       = '0;
    unique case (state_q)
      kce_pkg::ST_IDLE: s_axis_tready = 1'b1;
      kce_pkg::ST_CHK0: rd_addr = last;
      kce_pkg::ST_CHKL: rd_addr = A_W'(1);
      kce_pkg::ST_SCAN: rd_addr = s_q + A_W'(1);
      kce_pkg::ST_LIN_T, kce_pkg::ST_BZ_T, kce_pkg::ST_BV_T: div_start = 1'b1;
      kce_pkg::ST_BZ_C, kce_pkg::ST_BV_C: cub_start = 1'b1;
      kce_pkg::ST_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kce_pkg::ST_IDLE: begin
        key_q  <= $signed(s_axis_tdata[37:6]);
        res_q  <= '0;
        path_q <= kce_pkg::PATH_EMPTY;
        conv_q <= 1'b0;
      end
      kce_pkg::ST_CHK0: begin
        seg0_q <= rd_entry;
        res_q  <= W_W'($signed(rd_entry.value));
        path_q <= kce_pkg::PATH_CLAMP;
      end
      kce_pkg::ST_CHKL: begin
        res_q <= W_W'($signed(rd_entry.value));
        s_q   <= A_W'(1);
      end
      kce_pkg::ST_SCAN: begin
        cur_q    <= W_W'(key_q);
        passes_q <= '0;
        if (scan_more) begin
          seg0_q <= rd_entry;
          s_q    <= s_q + A_W'(1);
        end else begin
          seg1_q <= rd_entry;
          res_q  <= W_W'($signed(seg0_q.value));
          if (seg_bez) begin
            path_q <= kce_pkg::PATH_BEZIER;
          end else if (seg_lin) begin
            path_q <= kce_pkg::PATH_LINEAR;
          end else begin
            path_q <= kce_pkg::PATH_CONST;
          end
        end
      end
      kce_pkg::ST_LIN_TW, kce_pkg::ST_BZ_TW, kce_pkg::ST_BV_TW: begin
        if (div_done) begin
          t_q <= div_quo;
        end
      end
      kce_pkg::ST_LIN_MUL: lin_prod_q <= lin_dv * $signed(D_W'(t_q));
      kce_pkg::ST_LIN_ADD: res_q <= lin_res;
      kce_pkg::ST_BZ_CHK: begin
        passes_q <= passes_q + 8'd1;
        if (within_tol) begin
          cur_q  <= cub_val;
          conv_q <= 1'b1;
        end else if (between) begin
          cur_q <= mid_sum[N_W-1:1];
        end else if (cub_val > cur_q) begin
          cur_q <= cur_q - W_W'(tol_q);
        end else begin
          cur_q <= cur_q + W_W'(tol_q);
        end
      end
      kce_pkg::ST_BV_CW: begin
        if (cub_done) begin
          res_q <= cub_val;
        end
      end
      default: ;
    endcase
  end

  // ---- result ----
  assign sat_hi = W_W'({1'b0, {(V_W-1){1'b1}}});
  assign sat_lo = -sat_hi - W_W'(1);

  always_comb begin
    priority if (res_q > sat_hi) begin
      m_axis_tdata = sat_hi[V_W-1:0];
    end else if (res_q < sat_lo) begin
      m_axis_tdata = sat_lo[V_W-1:0];
    end else begin
      m_axis_tdata = res_q[V_W-1:0];
    end
  end

  assign m_axis_tuser = {conv_q, path_q};

endmodule
